@@ design/crf_pkg.sv @@
// shared types and codes for the coalescing request queue
package crf_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int CONN_W    = 8;
   localparam int DEV_W     = 8;
   localparam int STAMP_W   = 32;
   localparam int PAYLOAD_W = 64;
   localparam int COUNT_W   = 5;

   // command codes
   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;
   localparam logic [1:0] CMD_INVAL = 2'd3;

   // one queued request as held in the entry memory
   typedef struct packed {
      logic [CONN_W-1:0]    conn;
      logic [DEV_W-1:0]     dev;
      logic [STAMP_W-1:0]   stamp;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   // one response transaction
   typedef struct packed {
      logic                 pop_valid;
      logic [CONN_W-1:0]    out_connection;
      logic [DEV_W-1:0]     out_device;
      logic [STAMP_W-1:0]   out_stamp;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [COUNT_W-1:0]   entry_count;
      logic                 full_flag;
      logic                 merged_flag;
   } rsp_type;

endpackage

@@ design/coalescing_request_fifo.sv @@
// Coalescing request queue. Requests are held in a single-port-read entry
// memory with a registered read port; one request transaction is taken at a
// time and yields exactly one response transaction. A push or invalidate
// scans the held entries oldest first, one entry per cycle through the
// memory read port: a push that misses appends after the scan, a push that
// merges stops on the matching entry. The output register lets the next
// request be accepted while a response still waits on rsp_stall.
module coalescing_request_fifo #(
   parameter int DEPTH = crf_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic [crf_pkg::CONN_W-1:0]           req_connection_id,
   input  logic [crf_pkg::DEV_W-1:0]            req_device_address,
   input  logic [crf_pkg::STAMP_W-1:0]          req_stamp,
   input  logic [crf_pkg::PAYLOAD_W-1:0]        req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_pop_valid,
   output logic [crf_pkg::CONN_W-1:0]           rsp_out_connection,
   output logic [crf_pkg::DEV_W-1:0]            rsp_out_device,
   output logic [crf_pkg::STAMP_W-1:0]          rsp_out_stamp,
   output logic [crf_pkg::PAYLOAD_W-1:0]        rsp_out_payload,
   output logic [crf_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic                                 rsp_full_flag,
   output logic                                 rsp_merged_flag
);

   localparam int AW = $clog2(DEPTH);

   logic                busy;
   logic                res_valid;
   crf_pkg::rsp_type    res;
   logic                res_take;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   crf_pkg::entry_type  wr_data;
   logic [AW-1:0]       rd_addr;
   crf_pkg::entry_type  rd_data;

   logic                rsp_valid_ff, rsp_valid_in;
   crf_pkg::rsp_type    rsp_ff;

   crf_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_command        (req_command),
      .req_connection_id  (req_connection_id),
      .req_device_address (req_device_address),
      .req_stamp          (req_stamp),
      .req_payload        (req_payload),
      .busy               (busy),
      .res_valid          (res_valid),
      .res                (res),
      .res_take           (res_take),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data)
   );

   crf_entry_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = busy;

   // output register loads when empty or being drained this cycle
   assign res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pop_valid      = rsp_ff.pop_valid;
   assign rsp_out_connection = rsp_ff.out_connection;
   assign rsp_out_device     = rsp_ff.out_device;
   assign rsp_out_stamp      = rsp_ff.out_stamp;
   assign rsp_out_payload    = rsp_ff.out_payload;
   assign rsp_entry_count    = rsp_ff.entry_count;
   assign rsp_full_flag      = rsp_ff.full_flag;
   assign rsp_merged_flag    = rsp_ff.merged_flag;

endmodule

@@ design/crf_entry_ram.sv @@
// entry memory: one write port, one registered read port
module crf_entry_ram #(
   parameter int DEPTH = crf_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  crf_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output crf_pkg::entry_type  rd_data
);

   crf_pkg::entry_type mem [DEPTH];
   crf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/crf_ctrl.sv @@
// command sequencer: pointers, occupancy and the read-modify-write scan
module crf_ctrl #(
   parameter int DEPTH = crf_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [1:0]                      req_command,
   input  logic [crf_pkg::CONN_W-1:0]      req_connection_id,
   input  logic [crf_pkg::DEV_W-1:0]       req_device_address,
   input  logic [crf_pkg::STAMP_W-1:0]     req_stamp,
   input  logic [crf_pkg::PAYLOAD_W-1:0]   req_payload,
   output logic                            busy,
   output logic                            res_valid,
   output crf_pkg::rsp_type                res,
   input  logic                            res_take,
   output logic                            wr_en,
   output logic [AW-1:0]                   wr_addr,
   output crf_pkg::entry_type              wr_data,
   output logic [AW-1:0]                   rd_addr,
   input  crf_pkg::entry_type              rd_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_APPEND = 3'd2;
   localparam logic [2:0] ST_POPRD  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          cmd_ff, cmd_in;
   crf_pkg::entry_type  ent_ff, ent_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [AW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       occ_ff, occ_in;
   logic [AW-1:0]       sidx_ff, sidx_in;
   logic [CW-1:0]       scnt_ff, scnt_in;
   crf_pkg::rsp_type    res_ff, res_in;

   logic                hit_conn;
   logic                hit;
   logic                last;
   logic [CW+4:0]       occ_wide;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign hit_conn = (rd_data.conn == ent_ff.conn);
   assign hit      = hit_conn && (rd_data.dev == ent_ff.dev);
   assign last     = ((scnt_ff + 1'b1) == occ_ff);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      ent_in   = ent_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      sidx_in  = sidx_ff;
      scnt_in  = scnt_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = sidx_ff;
      wr_data  = ent_ff;
      rd_addr  = head_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in         = req_command;
               ent_in.conn    = req_connection_id;
               ent_in.dev     = req_device_address;
               ent_in.stamp   = req_stamp;
               ent_in.payload = req_payload;
               sidx_in        = head_ff;
               scnt_in        = '0;
               res_in         = '0;
               case (req_command)
                  crf_pkg::CMD_PUSH: begin
                     state_in = (occ_ff == '0) ? ST_APPEND : ST_SCAN;
                  end
                  crf_pkg::CMD_POP: begin
                     state_in = (occ_ff == '0) ? ST_DONE : ST_POPRD;
                  end
                  crf_pkg::CMD_FLUSH: begin
                     head_in  = '0;
                     tail_in  = '0;
                     occ_in   = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = (occ_ff == '0) ? ST_DONE : ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // read data belongs to sidx_ff; next entry is fetched meanwhile
            rd_addr = next_slot(sidx_ff);
            sidx_in = next_slot(sidx_ff);
            scnt_in = scnt_ff + 1'b1;
            if (cmd_ff == crf_pkg::CMD_PUSH) begin
               if (hit) begin
                  wr_en              = 1'b1;
                  res_in.merged_flag = 1'b1;
                  state_in           = ST_DONE;
               end else if (last) begin
                  state_in = ST_APPEND;
               end
            end else begin
               if (hit_conn) begin
                  wr_en         = 1'b1;
                  wr_data       = rd_data;
                  wr_data.conn  = '0;
                  wr_data.stamp = '0;
               end
               if (last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = tail_ff;
            tail_in = next_slot(tail_ff);
            if (occ_ff < CW'(DEPTH)) begin
               occ_in = occ_ff + 1'b1;
            end else begin
               // full queue: oldest entry is overwritten
               head_in = next_slot(head_ff);
            end
            state_in = ST_DONE;
         end
         ST_POPRD: begin
            res_in.pop_valid      = 1'b1;
            res_in.out_connection = rd_data.conn;
            res_in.out_device     = rd_data.dev;
            res_in.out_stamp      = rd_data.stamp;
            res_in.out_payload    = rd_data.payload;
            head_in               = next_slot(head_ff);
            occ_in                = occ_ff - 1'b1;
            state_in              = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      ent_ff  <= ent_in;
      sidx_ff <= sidx_in;
      scnt_ff <= scnt_in;
      res_ff  <= res_in;
   end

   assign occ_wide = {5'b0, occ_ff};

   always_comb begin
      res             = res_ff;
      res.entry_count = occ_wide[4:0];
      res.full_flag   = (occ_ff == CW'(DEPTH));
   end

   assign busy      = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(DEPTH))
      else $error("occupancy exceeds depth");

   a_ptr_empty: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_scan_rw: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && wr_en) |-> (rd_addr != wr_addr))
      else $error("scan reads the entry it writes");

   a_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_command == crf_pkg::CMD_FLUSH)
      |=> (occ_ff == '0 && state_ff == ST_DONE))
      else $error("flush did not empty the queue");

   a_merge_excl: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(res.merged_flag && res.pop_valid))
      else $error("merged and pop reported together");
`endif

endmodule
